// File: hdl/msp_rx_pkg.sv
package msp_rx_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_RC_ID     = 2'd2;

    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd64;
    localparam logic [15:0] RST_RAW_RC_ID     = 16'd200;

    // Input beat kinds
    localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RC_SENT = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame end status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_ECHO     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_ERR_HDR  = 3'd4;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_V1     = 8'h4D;
    localparam logic [7:0] CH_V2     = 8'h58;
    localparam logic [7:0] CH_TO_FC  = 8'h3C;
    localparam logic [7:0] CH_FROM_FC = 8'h3E;
    localparam logic [7:0] CH_ERROR  = 8'h21;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam int unsigned OUT_TDATA_W = 64;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] max_payload;
        logic [15:0] raw_rc_id;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [2:0]  status;
        logic        is_v2;
        logic [15:0] message_id;
        logic [15:0] payload_size;
    } result_t;

    // CRC-8 DVB-S2, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/msp_rx_parser.sv
module msp_rx_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [1:0]          func,
    input  logic [7:0]          rx_byte,
    input  msp_rx_pkg::cfg_t    cfg,
    output msp_rx_pkg::result_t res
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_DOLLAR,
        PH_VER,
        PH_V1_SIZE,
        PH_V1_ID,
        PH_V2_FLAG,
        PH_V2_ID0,
        PH_V2_ID1,
        PH_V2_SZ0,
        PH_V2_SZ1,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        v2_reg, v2_next;
    logic [7:0]  check_reg, check_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        echo_reg, echo_next;

    logic [7:0]  check_acc;
    logic [15:0] elapsed_inc;
    logic [16:0] count_plus;
    logic        late;
    logic        go_hunt;
    logic        emit;
    logic [2:0]  emit_status;

    assign check_acc   = v2_reg ? msp_rx_pkg::crc8_step(check_reg, rx_byte)
                                : (check_reg ^ rx_byte);
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign count_plus  = {1'b0, count_reg} + 17'd1;
    assign late = (phase_reg == PH_PAYLOAD || phase_reg == PH_CHECK)
                ? (elapsed_inc > cfg.timeout_ticks)
                : (elapsed_inc >= cfg.timeout_ticks);

    always_comb
    begin
        phase_next   = phase_reg;
        v2_next      = v2_reg;
        check_next   = check_reg;
        id_next      = id_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        echo_next    = echo_reg;
        go_hunt      = 1'b0;
        emit         = 1'b0;
        emit_status  = msp_rx_pkg::ST_OK;

        res              = '0;
        res.is_v2        = v2_reg;
        res.message_id   = id_reg;
        res.payload_size = size_reg;

        if (beat)
        begin
            case (func)
                msp_rx_pkg::FUNC_RC_SENT:
                begin
                    echo_next = 1'b1;
                end
                msp_rx_pkg::FUNC_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (late)
                    begin
                        emit        = 1'b1;
                        emit_status = msp_rx_pkg::ST_TIMEOUT;
                    end
                end
                msp_rx_pkg::FUNC_RX_BYTE:
                begin
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            if (rx_byte == msp_rx_pkg::CH_DOLLAR)
                                phase_next = PH_DOLLAR;
                        end
                        PH_DOLLAR:
                        begin
                            if (rx_byte == msp_rx_pkg::CH_V1 || rx_byte == msp_rx_pkg::CH_V2)
                            begin
                                v2_next    = (rx_byte == msp_rx_pkg::CH_V2);
                                phase_next = PH_VER;
                            end
                            else
                                go_hunt = 1'b1;
                        end
                        PH_VER:
                        begin
                            if (rx_byte == msp_rx_pkg::CH_FROM_FC
                                || rx_byte == msp_rx_pkg::CH_TO_FC)
                                phase_next = v2_reg ? PH_V2_FLAG : PH_V1_SIZE;
                            else if (rx_byte == msp_rx_pkg::CH_ERROR)
                            begin
                                emit        = 1'b1;
                                emit_status = msp_rx_pkg::ST_ERR_HDR;
                            end
                            else
                                go_hunt = 1'b1;
                        end
                        PH_V1_SIZE:
                        begin
                            size_next  = {8'd0, rx_byte};
                            check_next = check_acc;
                            phase_next = PH_V1_ID;
                        end
                        PH_V1_ID:
                        begin
                            id_next    = {8'd0, rx_byte};
                            check_next = check_acc;
                            phase_next = (size_reg == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                        PH_V2_FLAG:
                        begin
                            check_next = check_acc;
                            phase_next = PH_V2_ID0;
                        end
                        PH_V2_ID0:
                        begin
                            id_next    = {8'd0, rx_byte};
                            check_next = check_acc;
                            phase_next = PH_V2_ID1;
                        end
                        PH_V2_ID1:
                        begin
                            id_next    = {rx_byte, id_reg[7:0]};
                            check_next = check_acc;
                            phase_next = PH_V2_SZ0;
                        end
                        PH_V2_SZ0:
                        begin
                            size_next  = {8'd0, rx_byte};
                            check_next = check_acc;
                            phase_next = PH_V2_SZ1;
                        end
                        PH_V2_SZ1:
                        begin
                            size_next  = {rx_byte, size_reg[7:0]};
                            check_next = check_acc;
                            phase_next = ({rx_byte, size_reg[7:0]} == 16'd0)
                                       ? PH_CHECK : PH_PAYLOAD;
                        end
                        PH_PAYLOAD:
                        begin
                            check_next = check_acc;
                            count_next = count_plus[15:0];
                            if (count_reg < cfg.max_payload)
                            begin
                                res.valid        = 1'b1;
                                res.kind         = msp_rx_pkg::KIND_PAYLOAD;
                                res.payload_byte = rx_byte;
                                res.byte_index   = count_reg;
                            end
                            if (count_plus >= {1'b0, size_reg})
                                phase_next = PH_CHECK;
                        end
                        PH_CHECK:
                        begin
                            emit = 1'b1;
                            if (rx_byte != check_reg)
                                emit_status = msp_rx_pkg::ST_MISMATCH;
                            else if (id_reg == cfg.raw_rc_id && echo_reg)
                            begin
                                emit_status = msp_rx_pkg::ST_ECHO;
                                echo_next   = 1'b0;
                            end
                            else
                                emit_status = msp_rx_pkg::ST_OK;
                        end
                        default:
                        begin
                            go_hunt = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
        begin
            res.valid  = 1'b1;
            res.kind   = msp_rx_pkg::KIND_STATUS;
            res.status = emit_status;
            go_hunt    = 1'b1;
        end

        // drop the frame and restart the search window
        if (go_hunt)
        begin
            phase_next   = PH_HUNT;
            v2_next      = 1'b0;
            check_next   = 8'd0;
            id_next      = 16'd0;
            size_next    = 16'd0;
            count_next   = 16'd0;
            elapsed_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            v2_reg      <= 1'b0;
            check_reg   <= 8'd0;
            id_reg      <= 16'd0;
            size_reg    <= 16'd0;
            count_reg   <= 16'd0;
            elapsed_reg <= 16'd0;
            echo_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            v2_reg      <= v2_next;
            check_reg   <= check_next;
            id_reg      <= id_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            echo_reg    <= echo_next;
        end
    end

endmodule

// File: hdl/msp_frame_receiver_top.sv
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: kind; tdata: payload fields
// cfg       in   cfg_we                       cfg_index, cfg_data
//
// One input beat per cycle; the parser state advances in the accept cycle and
// a result, if any, appears on m_axis the next cycle from the output register.
// The rate is set by the single output register: a new beat is taken whenever
// it is empty or being drained, so a stalled m_axis blocks s_axis.
// Reset (rst_n low, asynchronous) returns the parser to hunting for '$',
// clears the pending echo and loads register defaults; no clearing pass.
module msp_frame_receiver_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // rx_byte
    input  logic [1:0]                          s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // payload_byte[7:0], byte_index[23:8], status[26:24], is_v2[27],
    // message_id[43:28], payload_size[59:44], zero[63:60]
    output logic [msp_rx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tuser,  // kind
    input  logic                                cfg_we,
    input  logic [msp_rx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_rx_pkg::CFG_DATA_W-1:0]  cfg_data
);

    msp_rx_pkg::cfg_t    cfg_reg;
    msp_rx_pkg::result_t res;

    logic                                m_valid_reg;
    logic                                m_kind_reg;
    logic [msp_rx_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                                s_accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= msp_rx_pkg::RST_TIMEOUT_TICKS;
            cfg_reg.max_payload   <= msp_rx_pkg::RST_MAX_PAYLOAD;
            cfg_reg.raw_rc_id     <= msp_rx_pkg::RST_RAW_RC_ID;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msp_rx_pkg::REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                msp_rx_pkg::REG_MAX_PAYLOAD:   cfg_reg.max_payload   <= cfg_data;
                msp_rx_pkg::REG_RAW_RC_ID:     cfg_reg.raw_rc_id     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    msp_rx_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (s_accept),
        .func    (s_axis_tuser),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_accept)
            m_valid_reg <= res.valid;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && res.valid)
        begin
            m_kind_reg <= res.kind;
            m_data_reg <= {4'd0, res.payload_size, res.message_id, res.is_v2,
                           res.status, res.byte_index, res.payload_byte};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = m_data_reg;

    a_rc_sent_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tuser == msp_rx_pkg::FUNC_RC_SENT |-> !res.valid)
        else $error("raw-RC notice produced a result");

    a_payload_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == msp_rx_pkg::KIND_PAYLOAD
        |-> res.byte_index < cfg_reg.max_payload)
        else $error("payload beat past max_payload");

    a_timeout_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == msp_rx_pkg::KIND_STATUS
        && res.status == msp_rx_pkg::ST_TIMEOUT
        |-> s_accept && s_axis_tuser == msp_rx_pkg::FUNC_TICK)
        else $error("timeout status without a tick beat");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && res.valid |=> m_axis_tvalid)
        else $error("result beat lost");

endmodule
